>>> design/krq_pkg.sv
// Shared types and constants of the keyboard report queue.
// Depends on nothing; the top-level queue module imports it.
package krq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_SPAN    = 2 * QUEUE_DEPTH;
    localparam int PTR_W       = $clog2(PTR_SPAN);
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int REPORT_W    = 64;

    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_FLUSH  = 2'd1;
    localparam logic [1:0] CMD_ATTACH = 2'd2;
    localparam logic [1:0] CMD_RESUME = 2'd3;

    localparam logic [2:0] ST_SENT      = 3'd0;
    localparam logic [2:0] ST_BUSY      = 3'd1;
    localparam logic [2:0] ST_REFUSED   = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_OVERWROTE = 3'd4;
    localparam logic [2:0] ST_NOTHING   = 3'd5;

    typedef struct packed {
        logic [1:0]          command;
        logic [REPORT_W-1:0] report;
        logic                endpoint_ready;
        logic                send_ok;
    } request_t;

    typedef struct packed {
        logic                send_valid;
        logic [REPORT_W-1:0] send_report;
        logic [2:0]          status;
        logic [3:0]          depth;
        logic [3:0]          depth_peak;
    } result_t;

endpackage

>>> design/keyboard_report_queue_top.sv
// Top level of the keyboard report queue: command decode, pointers, duplicate record.
// Depends on krq_pkg and krq_slot_ram.

// Usage: the block takes one command item in every clock cycle; busy never rises.
// The result item of a command shows on result for exactly one cycle, marked by
// done, in the cycle right after start was taken; the receiver cannot stall it,
// so it must capture result whenever done is high. That delay comes from
// the registered read port of the slot memory: the head report is read at the
// accept edge and leaves on the next cycle. Slots have no reset; only reports
// from written slots are ever sent, so none is needed.
module keyboard_report_queue_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  krq_pkg::request_t request,
    output logic              done,
    output krq_pkg::result_t  result
);
    import krq_pkg::*;

    // Pointer helpers: pointers run modulo twice the depth.
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] s;
        s = {1'b0, p} + (PTR_W+1)'(1);
        return (s >= (PTR_W+1)'(PTR_SPAN)) ? '0 : s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] s;
        s = (p == '0) ? (PTR_W+1)'(PTR_SPAN - 1) : ({1'b0, p} - (PTR_W+1)'(1));
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ptr_index(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] s;
        s = ({1'b0, p} >= (PTR_W+1)'(QUEUE_DEPTH)) ?
            ({1'b0, p} - (PTR_W+1)'(QUEUE_DEPTH)) : {1'b0, p};
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [FILL_W-1:0] fill_of(input logic [PTR_W-1:0] w,
                                                  input logic [PTR_W-1:0] r);
        logic [PTR_W:0] s;
        s = (w >= r) ? ({1'b0, w} - {1'b0, r})
                     : ({1'b0, w} + (PTR_W+1)'(PTR_SPAN) - {1'b0, r});
        return s[FILL_W-1:0];
    endfunction

    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [REPORT_W-1:0] last_reg, last_next;
    logic                last_valid_reg, last_valid_next;
    logic [FILL_W-1:0]   peak_reg, peak_next;

    // Result fields held for the strobe cycle.
    logic                done_reg;
    logic                sent_reg, sent_next;
    logic [2:0]          status_reg, status_next;
    logic [FILL_W-1:0]   depth_reg, depth_next;
    logic                fwd_reg, fwd_next;
    logic [REPORT_W-1:0] fwd_data_reg;

    logic                accept;
    logic [FILL_W-1:0]   fill_now, fill_after;
    logic                is_dup, is_full, do_append, do_overwrite, do_offer;
    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr, ram_rd_addr;
    logic [REPORT_W-1:0] ram_rd_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        fill_now     = fill_of(wr_ptr_reg, rd_ptr_reg);
        is_dup       = (request.command == CMD_SUBMIT) && last_valid_reg
                       && (last_reg == request.report);
        is_full      = fill_now >= FILL_W'(QUEUE_DEPTH);
        do_append    = (request.command == CMD_SUBMIT) && !is_dup && !is_full;
        do_overwrite = (request.command == CMD_SUBMIT) && !is_dup && is_full;
        do_offer     = do_append || (request.command == CMD_FLUSH);

        wr_ptr_next     = do_append ? ptr_next(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        last_next       = last_reg;
        last_valid_next = last_valid_reg;
        peak_next       = peak_reg;
        sent_next       = 1'b0;
        status_next     = ST_NOTHING;

        fill_after = do_append ? fill_now + FILL_W'(1) : fill_now;

        if ((request.command == CMD_SUBMIT) && !is_dup)
        begin
            last_next       = request.report;
            last_valid_next = 1'b1;
        end
        if (do_append && (fill_after > peak_reg))
        begin
            peak_next = fill_after;
        end

        case (request.command)
            CMD_SUBMIT:
            begin
                if (is_dup)
                begin
                    status_next = ST_DUPLICATE;
                end
                else if (do_overwrite)
                begin
                    status_next = ST_OVERWROTE;
                end
            end
            CMD_ATTACH:
            begin
                last_valid_next = 1'b0;
                rd_ptr_next     = wr_ptr_reg;
            end
            CMD_RESUME:
            begin
                last_valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        // Offer the head: an append offers at once, a flush offers explicitly.
        if (do_offer)
        begin
            if (fill_after == '0)
            begin
                status_next = ST_NOTHING;
            end
            else if (!request.endpoint_ready)
            begin
                status_next = ST_BUSY;
            end
            else if (!request.send_ok)
            begin
                status_next = ST_REFUSED;
            end
            else
            begin
                status_next = ST_SENT;
                sent_next   = 1'b1;
                rd_ptr_next = ptr_next(rd_ptr_reg);
            end
        end

        depth_next = fill_of(wr_ptr_next, rd_ptr_next);

        ram_wr_en   = accept && (do_append || do_overwrite);
        ram_wr_addr = do_append ? ptr_index(wr_ptr_reg) : ptr_index(ptr_prev(wr_ptr_reg));
        ram_rd_addr = ptr_index(rd_ptr_reg);

        // Forward the report when the head is the slot written in this same cycle.
        fwd_next = ram_wr_en && (ram_wr_addr == ram_rd_addr);
    end

    krq_slot_ram #(
        .WIDTH  (REPORT_W),
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (request.report),
        .rd_en   (accept),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            last_reg       <= '0;
            last_valid_reg <= 1'b0;
            peak_reg       <= '0;
            done_reg       <= 1'b0;
            sent_reg       <= 1'b0;
            status_reg     <= ST_NOTHING;
            depth_reg      <= '0;
            fwd_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                wr_ptr_reg     <= wr_ptr_next;
                rd_ptr_reg     <= rd_ptr_next;
                last_reg       <= last_next;
                last_valid_reg <= last_valid_next;
                peak_reg       <= peak_next;
                sent_reg       <= sent_next;
                status_reg     <= status_next;
                depth_reg      <= depth_next;
                fwd_reg        <= fwd_next;
            end
        end
    end

    // Forwarded report is payload: no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= request.report;
        end
    end

    assign done = done_reg;

    always_comb
    begin
        result.send_valid  = sent_reg;
        result.send_report = sent_reg ? (fwd_reg ? fwd_data_reg : ram_rd_data) : '0;
        result.status      = status_reg;
        result.depth       = 4'(depth_reg);
        result.depth_peak  = 4'(peak_reg);
    end

    // Every accepted item yields its result on the next cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after accepted item");

    // A transmitted report always carries the sent status.
    a_sent_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.send_valid) |-> (result.status == ST_SENT))
        else $error("send_valid without sent status");

    // The fill level never goes past the queue depth.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_of(wr_ptr_reg, rd_ptr_reg) <= FILL_W'(QUEUE_DEPTH)))
        else $error("queue fill above depth");

    // The peak covers every depth reached, since depth only grows by append.
    a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_of(wr_ptr_reg, rd_ptr_reg) <= peak_reg))
        else $error("depth above recorded peak");

endmodule

>>> design/krq_slot_ram.sv
// Simple dual-port slot memory: one write port, one read port, read data registered.
// Generic; no package dependencies.
module krq_slot_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
